// File: rtl/core/ttip_pkg.sv
// Shared constants, types and the character-to-digit decode for the text-to-integer parser.
// No dependencies; imported by ttip_digit_mac and text_to_integer_parser.
`timescale 1ns / 1ps

package ttip_pkg;

   // Widths fixed by the word format.
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned BASE_W  = 6;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned DIGIT_W = 7;

   // Character codes.
   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
   localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
   localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

   // Radix values.
   localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
   localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

   // Digit value of a character that is no digit at all; never below any radix.
   localparam logic [DIGIT_W-1:0] NOT_DIGIT = 7'd64;

   // Digit decode result handed back by the digit unit.
   typedef struct packed {
      logic               digit_ok;
      logic [VALUE_W-1:0] next_value;
   } digit_result_type;

   // Map a character to its digit value: 0-9, then letters of either case as 10-35.
   function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
      logic [DIGIT_W-1:0] d;
      d = NOT_DIGIT;
      if (c >= CH_0 && c <= CH_9) begin
         d = DIGIT_W'(c - CH_0);
      end else if (c >= CH_LA && c <= CH_LZ) begin
         d = DIGIT_W'(c - CH_LA) + 7'd10;
      end else if (c >= CH_UA && c <= CH_UZ) begin
         d = DIGIT_W'(c - CH_UA) + 7'd10;
      end
      return d;
   endfunction

   // Whitespace that may precede the number.
   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
             (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
   endfunction

endpackage

// File: rtl/core/ttip_digit_mac.sv
// Digit decode and multiply-add for one character: value * radix + digit, modulo 2^64.
// Depends on ttip_pkg.
`timescale 1ns / 1ps

module ttip_digit_mac
   import ttip_pkg::*;
(
   input  logic [CHAR_W-1:0]  char_code,
   input  logic [BASE_W-1:0]  radix,
   input  logic [VALUE_W-1:0] value_in,
   output digit_result_type   result
);

   logic [DIGIT_W-1:0]         digit;
   logic [VALUE_W+BASE_W-1:0]  product;

   // A character is a digit when its value lies below the radix.
   assign digit = digit_of(char_code);
   assign result.digit_ok = ({1'b0, radix} > digit);

   // The product wraps; only the low 64 bits are kept.
   assign product = value_in * {{VALUE_W{1'b0}}, radix};
   assign result.next_value = product[VALUE_W-1:0] + {{(VALUE_W-DIGIT_W){1'b0}}, digit};

endmodule

// File: rtl/core/text_to_integer_parser.sv
// Top level of the streaming text-to-integer parser (strtoull / strtoll behavior).
// Depends on ttip_pkg and ttip_digit_mac.
`timescale 1ns / 1ps
//
// Usage:
//   Characters arrive one per word on the req_ channel; req_first_char marks the
//   first character of a new string and restarts the parse. Leading whitespace
//   and one sign are taken, then an optional 0x prefix and the digits. The first
//   character that is not a digit of the radix (NUL included) ends the string and
//   produces one result word on the rsp_ channel. Other characters produce none.
//   csr_number_base sets the radix used by the next string (0 selects it from the
//   prefix); write it only while no string is in flight.
// Throughput and pipeline:
//   One character per cycle while req_stall is low. A word enters an input register,
//   then the step logic (one 64 x 6 bit multiply-add) updates the parse state and
//   loads the result register; the result of the ending character passes through
//   both registers before it is visible on the rsp_ channel.
// Reset:
//   Synchronous, active high. Clears the parse state, both valid flags and the
//   radix register; characters that arrive before any first character are dropped.
// Stall:
//   While rsp_stall holds a waiting result, the step logic holds; one further
//   character is buffered in the input register and then req_stall rises.

module text_to_integer_parser
   import ttip_pkg::*;
#(
   parameter int MAX_LEN = 255
) (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       csr_write_enable,
   input  logic [BASE_W-1:0]          csr_number_base,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CHAR_W-1:0]          req_char_code,
   input  logic                       req_first_char,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [VALUE_W-1:0]         rsp_magnitude,
   output logic signed [VALUE_W-1:0]  rsp_signed_value,
   output logic                       rsp_is_negative,
   output logic [COUNT_W-1:0]         rsp_consumed_count,
   output logic                       rsp_no_digits
);

   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SPACE,
      PH_SIGN,
      PH_ZERO,
      PH_HEXSTART,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   // Configuration register.
   logic [BASE_W-1:0]  number_base_ff;

   // Input register.
   logic               in_valid_ff;
   logic [CHAR_W-1:0]  in_char_ff;
   logic               in_first_ff;

   // Parse state.
   phase_type          phase_ff, phase_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               minus_ff, minus_in;
   logic [BASE_W-1:0]  base_ff, base_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // Result register.
   logic               out_valid_ff;
   logic [VALUE_W-1:0] out_mag_ff, out_mag_in;
   logic [VALUE_W-1:0] out_sval_ff, out_sval_in;
   logic               out_neg_ff;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;
   logic               out_nodig_ff, out_nodig_in;
   logic               result_in;

   // Step control.
   logic               advance;
   logic               fire;
   phase_type          cur_phase;
   logic [VALUE_W-1:0] cur_acc;
   logic               cur_minus;
   logic [BASE_W-1:0]  cur_base;
   logic [CNT_W-1:0]   cur_cnt;
   logic [CNT_W-1:0]   cnt_inc;
   logic [BASE_W-1:0]  radix;
   logic               is_x;
   logic [CNT_W+COUNT_W-1:0] cnt_wide;
   digit_result_type   dig;

   // The step logic moves when the result register is free or being emptied.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   // A first character restarts from a clean state before it is evaluated.
   always_comb begin
      if (in_first_ff) begin
         cur_phase = PH_SPACE;
         cur_acc   = '0;
         cur_minus = 1'b0;
         cur_base  = number_base_ff;
         cur_cnt   = '0;
      end else begin
         cur_phase = phase_ff;
         cur_acc   = acc_ff;
         cur_minus = minus_ff;
         cur_base  = base_ff;
         cur_cnt   = cnt_ff;
      end
   end

   assign cnt_inc = (cur_cnt < CNT_MAX) ? cur_cnt + 1'b1 : cur_cnt;
   assign is_x    = (in_char_ff == CH_LX) || (in_char_ff == CH_UX);

   // Radix in force for this character once the prefix rules are applied.
   always_comb begin
      radix = cur_base;
      if (cur_base == BASE_AUTO) begin
         if (cur_phase == PH_ZERO) begin
            radix = BASE_OCT;
         end else if (cur_phase == PH_SPACE || cur_phase == PH_SIGN) begin
            radix = BASE_DEC;
         end
      end
   end

   // The accumulator stays zero until the digit phase, so the first digit
   // comes out of the same multiply-add as every later one.
   ttip_digit_mac u_mac (
      .char_code (in_char_ff),
      .radix     (radix),
      .value_in  (cur_acc),
      .result    (dig)
   );

   assign cnt_wide = {{COUNT_W{1'b0}}, cur_cnt};

   // Next parse state and result for the character in the input register.
   always_comb begin
      phase_in     = cur_phase;
      acc_in       = cur_acc;
      minus_in     = cur_minus;
      base_in      = cur_base;
      cnt_in       = cur_cnt;
      result_in    = 1'b0;
      out_mag_in   = '0;
      out_count_in = '0;
      out_nodig_in = 1'b1;

      unique case (cur_phase)
         PH_SPACE, PH_SIGN: begin
            if (cur_phase == PH_SPACE && is_space(in_char_ff)) begin
               cnt_in = cnt_inc;
            end else if (cur_phase == PH_SPACE &&
                         (in_char_ff == CH_PLUS || in_char_ff == CH_MINUS)) begin
               minus_in = (in_char_ff == CH_MINUS);
               cnt_in   = cnt_inc;
               phase_in = PH_SIGN;
            end else if ((cur_base == BASE_AUTO || cur_base == BASE_HEX) &&
                         in_char_ff == CH_0) begin
               acc_in   = '0;
               cnt_in   = cnt_inc;
               phase_in = PH_ZERO;
            end else begin
               base_in = radix;
               if (dig.digit_ok) begin
                  acc_in   = dig.next_value;
                  cnt_in   = cnt_inc;
                  phase_in = PH_DIGITS;
               end else begin
                  result_in = 1'b1;
                  phase_in  = PH_DONE;
               end
            end
         end
         PH_ZERO: begin
            if (is_x) begin
               base_in  = BASE_HEX;
               cnt_in   = cnt_inc;
               phase_in = PH_HEXSTART;
            end else begin
               base_in = radix;
               if (dig.digit_ok) begin
                  acc_in   = dig.next_value;
                  cnt_in   = cnt_inc;
                  phase_in = PH_DIGITS;
               end else begin
                  result_in    = 1'b1;
                  out_mag_in   = cur_acc;
                  out_count_in = cnt_wide[COUNT_W-1:0];
                  out_nodig_in = 1'b0;
                  phase_in     = PH_DONE;
               end
            end
         end
         PH_HEXSTART: begin
            if (dig.digit_ok) begin
               acc_in   = dig.next_value;
               cnt_in   = cnt_inc;
               phase_in = PH_DIGITS;
            end else begin
               result_in = 1'b1;
               phase_in  = PH_DONE;
            end
         end
         PH_DIGITS: begin
            if (dig.digit_ok) begin
               acc_in = dig.next_value;
               cnt_in = cnt_inc;
            end else begin
               result_in    = 1'b1;
               out_mag_in   = cur_acc;
               out_count_in = cnt_wide[COUNT_W-1:0];
               out_nodig_in = 1'b0;
               phase_in     = PH_DONE;
            end
         end
         PH_IDLE, PH_DONE: begin
            phase_in = cur_phase;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      out_sval_in = cur_minus ? (~out_mag_in + 1'b1) : out_mag_in;
   end

   // State, input word and result word registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= BASE_AUTO;
         in_valid_ff    <= 1'b0;
         phase_ff       <= PH_IDLE;
         acc_ff         <= '0;
         minus_ff       <= 1'b0;
         base_ff        <= BASE_AUTO;
         cnt_ff         <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            number_base_ff <= csr_number_base;
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
            in_char_ff  <= req_char_code;
            in_first_ff <= req_first_char;
         end
         if (fire) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            minus_ff <= minus_in;
            base_ff  <= base_in;
            cnt_ff   <= cnt_in;
         end
         if (advance) begin
            out_valid_ff <= fire && result_in;
            out_mag_ff   <= out_mag_in;
            out_sval_ff  <= out_sval_in;
            out_neg_ff   <= cur_minus;
            out_count_ff <= out_count_in;
            out_nodig_ff <= out_nodig_in;
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_magnitude      = out_mag_ff;
   assign rsp_signed_value   = out_sval_ff;
   assign rsp_is_negative    = out_neg_ff;
   assign rsp_consumed_count = out_count_ff;
   assign rsp_no_digits      = out_nodig_ff;

endmodule

// File: sim/text_to_integer_parser_test.sv
// Self-checking testbench for text_to_integer_parser: directed and random character strings
// under several radix settings, with random idling on both channels. Depends on ttip_pkg.
`timescale 1ns / 1ps

module text_to_integer_parser_test;
   import ttip_pkg::*;

   localparam int unsigned MAX_COUNT    = 255;
   localparam int unsigned NO_VALUE     = 64;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned QUIET_LIMIT  = 300;
   localparam int unsigned PHASE_WORDS  = 115;
   localparam int unsigned LONG_BLANKS  = 250;

   // Radix used by each random phase; the long string goes into the decimal phase.
   localparam logic [BASE_W-1:0] RADIX_PLAN [10] = '{BASE_AUTO, BASE_DEC, BASE_HEX, 6'd1,
      BASE_OCT, 6'd36, 6'd37, 6'd63, 6'd2, BASE_AUTO};
   localparam logic [CHAR_W-1:0] BLANK_CHARS [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF,
      CH_CR};

   typedef enum logic [2:0] {
      ST_IDLE, ST_BLANKS, ST_SIGN, ST_ZERO, ST_HEX, ST_DIGITS, ST_DONE
   } parse_state_type;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              first;
   } char_word_type;

   typedef struct packed {
      logic [VALUE_W-1:0] magnitude;
      logic [VALUE_W-1:0] signed_value;
      logic               is_negative;
      logic [COUNT_W-1:0] consumed;
      logic               no_digits;
   } number_word_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [BASE_W-1:0]         csr_number_base = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [CHAR_W-1:0]         req_char_code = '0;
   logic                      req_first_char = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [VALUE_W-1:0]        rsp_magnitude;
   logic signed [VALUE_W-1:0] rsp_signed_value;
   logic                      rsp_is_negative;
   logic [COUNT_W-1:0]        rsp_consumed_count;
   logic                      rsp_no_digits;

   text_to_integer_parser dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_number_base    (csr_number_base),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_code      (req_char_code),
      .req_first_char     (req_first_char),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_magnitude      (rsp_magnitude),
      .rsp_signed_value   (rsp_signed_value),
      .rsp_is_negative    (rsp_is_negative),
      .rsp_consumed_count (rsp_consumed_count),
      .rsp_no_digits      (rsp_no_digits)
   );

   always #2 clock = ~clock;

   char_word_type   pending_chars[$];
   number_word_type expected_numbers[$];
   int unsigned     words_sent = 0;
   int unsigned     words_taken = 0;
   int unsigned     numbers_seen = 0;
   int unsigned     failures = 0;
   int unsigned     quiet_cycles = 0;

   // Parser state as the block should hold it.
   parse_state_type    prs_state = ST_IDLE;
   logic [VALUE_W-1:0] prs_value = '0;
   logic               prs_minus = 1'b0;
   logic [BASE_W-1:0]  prs_radix = '0;
   logic [COUNT_W-1:0] prs_count = '0;
   logic [BASE_W-1:0]  radix_setting = BASE_AUTO;

   // Digit value of a character, or NO_VALUE when it is neither a figure nor a letter.
   function automatic int unsigned char_value(input logic [CHAR_W-1:0] c);
      if (c >= CH_0 && c <= CH_9) return c - CH_0;
      if (c >= CH_LA && c <= CH_LZ) return c - CH_LA + 10;
      if (c >= CH_UA && c <= CH_UZ) return c - CH_UA + 10;
      return NO_VALUE;
   endfunction

   // Character for a digit value; letters come in either case.
   function automatic logic [CHAR_W-1:0] digit_char(input int unsigned d);
      if (d < 10) return CH_0 + CHAR_W'(d);
      if ($urandom_range(0, 1)) return CH_LA + CHAR_W'(d - 10);
      return CH_UA + CHAR_W'(d - 10);
   endfunction

   // Idle cycles before the next word; steady stretches never idle.
   function automatic int unsigned draw_wait(input logic steady);
      if (steady || $urandom_range(0, 1)) return 0;
      return $urandom_range(1, 13);
   endfunction

   task automatic bump_count();
      if (prs_count < MAX_COUNT) prs_count++;
   endtask

   // The terminating character: one result, then nothing until the next string.
   task automatic close_number(input logic had_digits);
      number_word_type n;
      n.magnitude    = had_digits ? prs_value : '0;
      n.signed_value = prs_minus ? -n.magnitude : n.magnitude;
      n.is_negative  = prs_minus;
      n.consumed     = had_digits ? prs_count : '0;
      n.no_digits    = !had_digits;
      expected_numbers.push_back(n);
      prs_state = ST_DONE;
   endtask

   task automatic lead_digit(input logic [CHAR_W-1:0] c);
      int unsigned d;
      d = char_value(c);
      if (d < prs_radix) begin
         prs_value = VALUE_W'(d);
         bump_count();
         prs_state = ST_DIGITS;
      end else begin
         close_number(1'b0);
      end
   endtask

   // Accumulation wraps at 64 bits with no saturation.
   task automatic add_digit(input logic [CHAR_W-1:0] c);
      int unsigned d;
      d = char_value(c);
      if (d < prs_radix) begin
         prs_value = prs_value * VALUE_W'(prs_radix) + VALUE_W'(d);
         bump_count();
      end else begin
         close_number(1'b1);
      end
   endtask

   // A zero may open a prefix in automatic or hexadecimal radix.
   task automatic begin_number(input logic [CHAR_W-1:0] c);
      if ((prs_radix == BASE_AUTO || prs_radix == BASE_HEX) && c == CH_0) begin
         prs_value = '0;
         bump_count();
         prs_state = ST_ZERO;
      end else begin
         if (prs_radix == BASE_AUTO) prs_radix = BASE_DEC;
         lead_digit(c);
      end
   endtask

   task automatic parse_char(input logic [CHAR_W-1:0] c, input logic first);
      if (first) begin
         prs_state = ST_BLANKS;
         prs_value = '0;
         prs_minus = 1'b0;
         prs_radix = radix_setting;
         prs_count = '0;
      end
      case (prs_state)
         ST_BLANKS: begin
            if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_FF ||
                  c == CH_VT) begin
               bump_count();
            end else if (c == CH_PLUS || c == CH_MINUS) begin
               prs_minus = (c == CH_MINUS);
               bump_count();
               prs_state = ST_SIGN;
            end else begin
               begin_number(c);
            end
         end
         ST_SIGN: begin_number(c);
         ST_ZERO: begin
            if (c == CH_LX || c == CH_UX) begin
               prs_radix = BASE_HEX;
               bump_count();
               prs_state = ST_HEX;
            end else begin
               if (prs_radix == BASE_AUTO) prs_radix = BASE_OCT;
               prs_state = ST_DIGITS;
               add_digit(c);
            end
         end
         ST_HEX: lead_digit(c);
         ST_DIGITS: add_digit(c);
         default: ;
      endcase
   endtask

   task automatic push_char(input logic [CHAR_W-1:0] c, input logic first);
      char_word_type w;
      w.code  = c;
      w.first = first;
      pending_chars.push_back(w);
      words_sent++;
   endtask

   // A whole string given as text, the first character marked.
   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i], i == 0);
   endtask

   // Wait until every word is taken and every number checked, then let the pipeline settle.
   task automatic wait_drained();
      do @(negedge clock);
      while (words_taken != words_sent || expected_numbers.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Character driver: one word at a time from the pending queue, with random gaps.
   int unsigned send_wait = 0;
   logic        send_steady = 1'b0;

   always @(posedge clock) begin
      char_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_char(req_char_code, req_first_char);
            words_taken++;
            send_wait = draw_wait(send_steady);
            if ($urandom_range(0, 49) == 0) send_steady = !send_steady;
         end
         if (!req_valid || !req_stall) begin
            if (send_wait == 0 && pending_chars.size() != 0) begin
               w = pending_chars.pop_front();
               req_valid      <= 1'b1;
               req_char_code  <= w.code;
               req_first_char <= w.first;
            end else begin
               req_valid <= 1'b0;
               if (send_wait != 0) send_wait--;
            end
         end
      end
   end

   // Result monitor: checks each number word against the oldest expectation.
   int unsigned hold_cycles = 0;
   logic        take_steady = 1'b0;

   always @(posedge clock) begin
      number_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            numbers_seen++;
            if (expected_numbers.size() == 0) begin
               $display("%0t: unexpected number word, magnitude %h", $time, rsp_magnitude);
               failures++;
            end else begin
               want = expected_numbers.pop_front();
               if (rsp_magnitude !== want.magnitude) begin
                  $display("%0t: magnitude expected %h actual %h", $time, want.magnitude,
                     rsp_magnitude);
                  failures++;
               end
               if (rsp_signed_value !== want.signed_value) begin
                  $display("%0t: signed_value expected %h actual %h", $time,
                     want.signed_value, rsp_signed_value);
                  failures++;
               end
               if (rsp_is_negative !== want.is_negative) begin
                  $display("%0t: is_negative expected %b actual %b", $time, want.is_negative,
                     rsp_is_negative);
                  failures++;
               end
               if (rsp_consumed_count !== want.consumed) begin
                  $display("%0t: consumed_count expected %0d actual %0d", $time, want.consumed,
                     rsp_consumed_count);
                  failures++;
               end
               if (rsp_no_digits !== want.no_digits) begin
                  $display("%0t: no_digits expected %b actual %b", $time, want.no_digits,
                     rsp_no_digits);
                  failures++;
               end
            end
            hold_cycles = draw_wait(take_steady);
            if ($urandom_range(0, 19) == 0) take_steady = !take_steady;
         end else if (!rsp_valid && hold_cycles == 0 && $urandom_range(0, 7) == 0) begin
            hold_cycles = draw_wait(take_steady);
         end
         rsp_stall <= (hold_cycles != 0);
         if (hold_cycles != 0) hold_cycles--;
      end
   end

   // Watchdog on cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("FAIL text_to_integer_parser");
            $finish;
         end
      end
   end

   initial begin
      logic [CHAR_W-1:0] text[$];
      logic [CHAR_W-1:0] c;
      logic [BASE_W-1:0] radix;
      logic              long_left;
      int unsigned       phase_start;
      int unsigned       eff;
      int unsigned       limit;
      int unsigned       digits;
      int unsigned       r;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed strings in automatic radix (the reset value).
      push_char("A", 1'b0);                          // before any string: dropped
      push_text(" -0xg");                            // bare hex prefix after a sign
      push_text("0;");                               // lone zero taken as a digit
      push_char("5", 1'b0);                          // after the end: dropped
      push_text("-");                                // sign with no digits
      push_char(CH_NUL, 1'b0);
      push_text("017");                              // octal
      push_char(CH_NUL, 1'b0);
      push_text("9");
      push_char(8'hFF, 1'b0);                        // top character code ends the string
      push_text("0X1");                              // upper-case prefix
      push_char(CH_NUL, 1'b0);
      push_text("+12");                              // cut off by a new string
      push_text("3");
      push_char(CH_NUL, 1'b0);

      for (int p = 0; p < 10; p++) begin
         wait_drained();
         radix = RADIX_PLAN[p];
         @(posedge clock);
         csr_write_enable <= 1'b1;
         csr_number_base  <= radix;
         radix_setting = radix;
         @(posedge clock);
         csr_write_enable <= 1'b0;

         long_left = (radix == BASE_DEC);
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) begin
            text = {};
            r = $urandom_range(0, 9);
            if (long_left) begin
               // Enough leading blanks to saturate the consumed count.
               repeat (LONG_BLANKS) text.push_back(BLANK_CHARS[$urandom_range(0, 5)]);
               text.push_back(CH_MINUS);
               repeat (8) text.push_back(digit_char($urandom_range(0, 9)));
               text.push_back(CH_NUL);
               long_left = 1'b0;
            end else if (r == 0) begin
               // Noise: raw characters with a random start flag.
               repeat ($urandom_range(1, 4))
                  push_char(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
               // Well-formed string: blanks, sign, prefix, digits, terminator, trailing junk.
               repeat ($urandom_range(0, 3)) text.push_back(BLANK_CHARS[$urandom_range(0, 5)]);
               r = $urandom_range(0, 2);
               if (r == 1) text.push_back(CH_PLUS);
               else if (r == 2) text.push_back(CH_MINUS);
               eff = (radix == BASE_AUTO) ? BASE_DEC : radix;
               r = $urandom_range(0, 7);
               if ((r < 3 && (radix == BASE_AUTO || radix == BASE_HEX)) || r == 7) begin
                  text.push_back(CH_0);
                  text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
                  if (radix == BASE_AUTO || radix == BASE_HEX) eff = BASE_HEX;
               end else if (r == 3 && radix == BASE_AUTO) begin
                  text.push_back(CH_0);
                  eff = BASE_OCT;
               end
               limit = (eff > 36) ? 36 : eff;
               r = $urandom_range(0, 9);
               digits = (r == 0) ? 0 : (r <= 6) ? $urandom_range(1, 6) :
                  (r <= 8) ? $urandom_range(7, 16) : $urandom_range(17, 30);
               repeat (digits) text.push_back(digit_char($urandom_range(0, limit - 1)));
               // One string in ten is left open and cut off by the next one.
               if ($urandom_range(0, 9) != 0) begin
                  if ($urandom_range(0, 1)) begin
                     text.push_back(CH_NUL);
                  end else begin
                     do c = CHAR_W'($urandom_range(0, 255));
                     while (char_value(c) < eff);
                     text.push_back(c);
                  end
                  repeat ($urandom_range(0, 2)) text.push_back(CHAR_W'($urandom_range(0, 255)));
               end
            end
            foreach (text[i]) push_char(text[i], i == 0);
         end
      end
      wait_drained();

      $display("Sent %0d characters over %0d radix settings; %0d numbers checked.",
         words_sent, 10, numbers_seen);
      $display("Mismatches found: %0d.", failures);
      if (failures == 0) begin
         $display("PASS text_to_integer_parser");
      end else begin
         $display("FAIL text_to_integer_parser");
      end
      $finish;
   end

endmodule
